@@ design/tuner_start_handshake_sequencer_assert.svh @@
// assertion macros for the sequencer top level
`ifndef TUNER_START_HANDSHAKE_SEQUENCER_ASSERT_SVH
`define TUNER_START_HANDSHAKE_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSSEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsseq check failed");

// next-cycle implication, checked outside reset
`define TSSEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsseq check failed");

`endif

@@ design/tsseq_pkg.sv @@
package tsseq_pkg;

   // run phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_WAIT   = 3'd1,
      PH_PULSE  = 3'd2,
      PH_TUNE   = 3'd3,
      PH_FINISH = 3'd4
   } phase_type;

   // register map
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam int unsigned REG_IDX_BITS  = 2;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned CFG_BITS      = 8;

   localparam logic [REG_IDX_BITS-1:0] REG_PULSE_TICK  = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_KEY_WAIT    = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_KEY_TIMEOUT = 2'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_TUNE_LIMIT  = 2'd3;

   // register reset values
   localparam logic [CFG_BITS-1:0] PULSE_TICK_RST  = 8'd1;
   localparam logic [CFG_BITS-1:0] KEY_WAIT_RST    = 8'd2;
   localparam logic [CFG_BITS-1:0] KEY_TIMEOUT_RST = 8'd10;
   localparam logic [CFG_BITS-1:0] TUNE_LIMIT_RST  = 8'd140;

   // timing settings seen by the core
   typedef struct packed {
      logic [CFG_BITS-1:0] pulse_tick;
      logic [CFG_BITS-1:0] key_wait_ticks;
      logic [CFG_BITS-1:0] key_timeout_ticks;
      logic [CFG_BITS-1:0] tune_limit_ticks;
   } cfg_type;

   // one pin poll
   typedef struct packed {
      logic start_n;
      logic manual_n;
      logic key;
      logic tick;
   } pins_type;

   // drive levels and phase after one poll
   typedef struct packed {
      logic      tune;
      logic      done_n;
      logic      busy;
      phase_type phase;
   } result_type;

endpackage

@@ design/tsseq_csr.sv @@
module tsseq_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [tsseq_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [tsseq_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [tsseq_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                   csr_pready,
   output tsseq_pkg::cfg_type                     cfg
);

   tsseq_pkg::cfg_type                    cfg_ff;
   logic                                  wr_en;
   logic [tsseq_pkg::REG_IDX_BITS-1:0]    idx;
   logic [tsseq_pkg::CFG_BITS-1:0]        rd_val;
   logic [tsseq_pkg::CFG_BITS-1:0]        wr_val;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[tsseq_pkg::CSR_ADDR_BITS-1:2];
   assign wr_val     = csr_pwdata[tsseq_pkg::CFG_BITS-1:0];

   // register writes on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_tick        <= tsseq_pkg::PULSE_TICK_RST;
         cfg_ff.key_wait_ticks    <= tsseq_pkg::KEY_WAIT_RST;
         cfg_ff.key_timeout_ticks <= tsseq_pkg::KEY_TIMEOUT_RST;
         cfg_ff.tune_limit_ticks  <= tsseq_pkg::TUNE_LIMIT_RST;
      end else if (wr_en) begin
         unique case (idx)
            tsseq_pkg::REG_PULSE_TICK:  cfg_ff.pulse_tick        <= wr_val;
            tsseq_pkg::REG_KEY_WAIT:    cfg_ff.key_wait_ticks    <= wr_val;
            tsseq_pkg::REG_KEY_TIMEOUT: cfg_ff.key_timeout_ticks <= wr_val;
            tsseq_pkg::REG_TUNE_LIMIT:  cfg_ff.tune_limit_ticks  <= wr_val;
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         tsseq_pkg::REG_PULSE_TICK:  rd_val = cfg_ff.pulse_tick;
         tsseq_pkg::REG_KEY_WAIT:    rd_val = cfg_ff.key_wait_ticks;
         tsseq_pkg::REG_KEY_TIMEOUT: rd_val = cfg_ff.key_timeout_ticks;
         tsseq_pkg::REG_TUNE_LIMIT:  rd_val = cfg_ff.tune_limit_ticks;
         default:                    rd_val = '0;
      endcase
   end

   assign csr_prdata = tsseq_pkg::CSR_DATA_BITS'(rd_val);
   assign cfg        = cfg_ff;

endmodule

@@ design/tsseq_core.sv @@
module tsseq_core #(
   parameter int unsigned COUNT_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  tsseq_pkg::pins_type    pins,
   input  tsseq_pkg::cfg_type     cfg,
   output tsseq_pkg::result_type  res_next
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   tsseq_pkg::phase_type   phase_ff, phase_in;
   logic                   manual_ff, manual_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in, count_tick;
   logic                   tune_ff, tune_in;
   logic                   done_n_ff, done_n_in;
   logic                   running;
   logic [COUNT_BITS-1:0]  pulse_at, wait_lim, timeout_lim, tune_lim;
   logic                   over;

   assign pulse_at    = COUNT_BITS'(cfg.pulse_tick);
   assign wait_lim    = COUNT_BITS'(cfg.key_wait_ticks);
   assign timeout_lim = COUNT_BITS'(cfg.key_timeout_ticks);
   assign tune_lim    = COUNT_BITS'(cfg.tune_limit_ticks);

   assign running = (phase_ff == tsseq_pkg::PH_WAIT) || (phase_ff == tsseq_pkg::PH_PULSE) ||
                    (phase_ff == tsseq_pkg::PH_TUNE) || (phase_ff == tsseq_pkg::PH_FINISH);

   // saturating tick count, only during a run
   assign count_tick = (running && pins.tick && (count_ff != COUNT_MAX)) ?
                       count_ff + COUNT_BITS'(1) : count_ff;
   assign over       = count_tick > tune_lim;

   // one phase decision per poll
   always_comb begin
      phase_in  = phase_ff;
      manual_in = manual_ff;
      count_in  = count_tick;
      tune_in   = tune_ff;
      done_n_in = done_n_ff;
      unique case (phase_ff)
         tsseq_pkg::PH_WAIT: begin
            if (count_tick >= pulse_at) begin
               tune_in  = 1'b1;
               phase_in = tsseq_pkg::PH_PULSE;
            end
         end
         tsseq_pkg::PH_PULSE: begin
            priority if (count_tick > wait_lim && pins.key) begin
               tune_in  = 1'b0;
               phase_in = tsseq_pkg::PH_TUNE;
            end else if (count_tick > timeout_lim) begin
               if (!manual_ff) done_n_in = 1'b0;
               phase_in = tsseq_pkg::PH_FINISH;
            end else begin
               // keep waiting for the key
               phase_in = tsseq_pkg::PH_PULSE;
            end
         end
         tsseq_pkg::PH_TUNE: begin
            if (count_tick > timeout_lim) begin
               if (manual_ff) begin
                  if (!pins.key || over) phase_in = tsseq_pkg::PH_FINISH;
               end else if (!pins.key || pins.start_n || over) begin
                  done_n_in = 1'b0;
                  phase_in  = tsseq_pkg::PH_FINISH;
               end
            end
         end
         tsseq_pkg::PH_FINISH: begin
            if (pins.start_n) begin
               tune_in   = 1'b0;
               done_n_in = 1'b1;
               manual_in = 1'b0;
               phase_in  = tsseq_pkg::PH_IDLE;
               count_in  = '0;
            end
         end
         default: begin
            // idle, and any code outside the run phases
            phase_in = tsseq_pkg::PH_IDLE;
            if (!pins.start_n || !pins.manual_n) begin
               tune_in   = 1'b0;
               done_n_in = 1'b1;
               manual_in = pins.start_n;
               phase_in  = tsseq_pkg::PH_WAIT;
               count_in  = '0;
            end
         end
      endcase
   end

   // run state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= tsseq_pkg::PH_IDLE;
         manual_ff <= 1'b0;
         count_ff  <= '0;
         tune_ff   <= 1'b0;
         done_n_ff <= 1'b1;
      end else if (step) begin
         phase_ff  <= phase_in;
         manual_ff <= manual_in;
         count_ff  <= count_in;
         tune_ff   <= tune_in;
         done_n_ff <= done_n_in;
      end
   end

   assign res_next.tune   = tune_in;
   assign res_next.done_n = done_n_in;
   assign res_next.busy   = phase_in != tsseq_pkg::PH_IDLE;
   assign res_next.phase  = phase_in;

endmodule

@@ design/tuner_start_handshake_sequencer.sv @@
// Tuner start handshake sequencer. Each req_ transfer is one poll of the pins
// (start and manual lines, active low, the tuner key and a timer tick flag); each
// produces exactly one rsp_ transfer with the tune drive, the active-low done
// drive, a busy flag and the phase after that poll. One poll is taken every clock
// cycle while the result side keeps up; a result is offered on rsp_ once its poll
// has passed from the input register through the core's state update into the
// result register, and is held there until rsp_ready takes it.
// Timing thresholds sit in four 8-bit registers at
// byte addresses 0, 4, 8 and 12 (pulse tick, key wait, key timeout, tune limit)
// and are meant to be written only while no poll is in flight.
module tuner_start_handshake_sequencer #(
   parameter int unsigned COUNT_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // poll channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_start_line_n,
   input  logic                                req_manual_line_n,
   input  logic                                req_key_line,
   input  logic                                req_tick,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_tune_drive,
   output logic                                rsp_done_drive_n,
   output logic                                rsp_busy_res,
   output logic [2:0]                          rsp_phase_now,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tsseq_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [tsseq_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [tsseq_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready
);

   `include "tuner_start_handshake_sequencer_assert.svh"

   tsseq_pkg::cfg_type     cfg;
   tsseq_pkg::pins_type    pins_ff;
   tsseq_pkg::result_type  res_next, res_ff;
   logic                   in_valid_ff, in_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   advance;
   logic                   req_xfer;

   tsseq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pins_ff.start_n  <= req_start_line_n;
         pins_ff.manual_n <= req_manual_line_n;
         pins_ff.key      <= req_key_line;
         pins_ff.tick     <= req_tick;
      end
      if (advance) begin
         res_ff <= res_next;
      end
   end

   tsseq_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .pins     (pins_ff),
      .cfg      (cfg),
      .res_next (res_next)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_tune_drive   = res_ff.tune;
   assign rsp_done_drive_n = res_ff.done_n;
   assign rsp_busy_res     = res_ff.busy;
   assign rsp_phase_now    = res_ff.phase;

   // done is only ever asserted in the finish phase
   `TSSEQ_ASSERT_NOW(a_done_in_finish, clock, reset, out_valid_ff && !res_ff.done_n, res_ff.phase == tsseq_pkg::PH_FINISH)
   // the tune pulse is only high in the pulse or finish phase
   `TSSEQ_ASSERT_NOW(a_tune_phase, clock, reset, out_valid_ff && res_ff.tune, (res_ff.phase == tsseq_pkg::PH_PULSE) || (res_ff.phase == tsseq_pkg::PH_FINISH))
   // busy follows the phase
   `TSSEQ_ASSERT_NOW(a_busy_phase, clock, reset, out_valid_ff, res_ff.busy == (res_ff.phase != tsseq_pkg::PH_IDLE))
   // a held poll is never dropped while the result side stalls
   `TSSEQ_ASSERT_NEXT(a_poll_held, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(pins_ff))

endmodule
